@@ rtl/core/clt_pkg.sv @@
// Package with the constants, codes and types of the command line tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package clt_pkg;

	localparam int MAX_LINE   = 128;
	localparam int NUM_VALUES = 8;
	localparam int OUT_VALUES = 8;
	localparam int LEN_W      = $clog2(MAX_LINE + 1);
	localparam int FI_W       = 4;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	localparam logic [2:0] CLS_TERM  = 3'd0;
	localparam logic [2:0] CLS_SPACE = 3'd1;
	localparam logic [2:0] CLS_MINUS = 3'd2;
	localparam logic [2:0] CLS_DIGIT = 3'd3;
	localparam logic [2:0] CLS_OTHER = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADCHAR = 2'd1;
	localparam logic [1:0] ST_TOOMANY = 2'd2;
	localparam logic [1:0] ST_TOOLONG = 2'd3;

	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] ch;
		logic [3:0] digit;
	} tok_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage
`default_nettype wire

@@ rtl/core/clt_in_if.sv @@
// Channel interface for received characters.
`timescale 1ns / 1ps
`default_nettype none
interface clt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/core/clt_out_if.sv @@
// Channel interface for parsed command lines.
`timescale 1ns / 1ps
`default_nettype none
interface clt_out_if;
	logic               valid;
	logic               ready;
	logic        [31:0] command_word;
	logic signed [31:0] value_0;
	logic signed [31:0] value_1;
	logic signed [31:0] value_2;
	logic signed [31:0] value_3;
	logic signed [31:0] value_4;
	logic signed [31:0] value_5;
	logic signed [31:0] value_6;
	logic signed [31:0] value_7;
	logic        [3:0]  value_count;
	logic        [1:0]  line_status;

	modport source (
		output valid, output command_word,
		output value_0, output value_1, output value_2, output value_3,
		output value_4, output value_5, output value_6, output value_7,
		output value_count, output line_status,
		input ready
	);
	modport sink (
		input valid, input command_word,
		input value_0, input value_1, input value_2, input value_3,
		input value_4, input value_5, input value_6, input value_7,
		input value_count, input line_status,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/core/command_line_tokenizer_unit.sv @@
// Top level of the command line tokenizer.
//
//   channel  | dir | payload                                        | per transaction
//   chars    | in  | rx_byte                                        | one character
//   tokens   | out | command_word, value_0..7, value_count, status  | one finished line
//
// One character is taken each cycle while the four-entry token queue has room.
// The line engine retires one queued token per cycle unless the result stalls;
// a line end after at least one character loads the result register as it retires.
// A stalled result blocks only the engine; the queue keeps taking characters
// until its four entries are full.
// Reset is asynchronous and clears the queue, the line state and the result valid.
`timescale 1ns / 1ps
`default_nettype none
module command_line_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	clt_in_if.sink     chars,
	clt_out_if.source  tokens
);
	import clt_pkg::*;

	hs_t  push;
	tok_t push_tok;
	logic push_ready;
	logic pop_valid;
	tok_t pop_tok;
	logic pop_ready;
	logic push_fire;

	assign push_fire = push.valid && push.ready;

	clt_front u_front (
		.chars      (chars),
		.push       (push),
		.push_tok   (push_tok),
		.push_ready (push_ready)
	);

	clt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push.valid),
		.push_tok   (push_tok),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_tok    (pop_tok),
		.pop_ready  (pop_ready)
	);

	clt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (pop_valid),
		.tok       (pop_tok),
		.tok_ready (pop_ready),
		.tokens    (tokens)
	);

	a_accept_means_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire |-> push_ready)
		else $error("character taken while queue full");

	a_ready_tracks_queue: assert property (@(posedge clk) disable iff (!arst_n)
		chars.ready == push_ready)
		else $error("input ready does not follow queue room");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pop_valid |=> !$rose(tokens.valid) || $past(pop_valid))
		else $error("result produced without a token");

endmodule
`default_nettype wire

@@ rtl/core/clt_front.sv @@
// Front end that classifies each received character into a token.
`timescale 1ns / 1ps
`default_nettype none
module clt_front (
	clt_in_if.sink       chars,
	output clt_pkg::hs_t push,
	output clt_pkg::tok_t push_tok,
	input  logic         push_ready
);
	import clt_pkg::*;

	logic [7:0] c;

	assign c = chars.rx_byte;

	always_comb begin
		push_tok.ch    = c;
		push_tok.digit = 4'(c - CH_ZERO);
		if (c inside {CH_LF, CH_CR}) begin
			push_tok.cls = CLS_TERM;
		end else if (c == CH_SPACE) begin
			push_tok.cls = CLS_SPACE;
		end else if (c == CH_MINUS) begin
			push_tok.cls = CLS_MINUS;
		end else if (c inside {[CH_ZERO:CH_NINE]}) begin
			push_tok.cls = CLS_DIGIT;
		end else begin
			push_tok.cls = CLS_OTHER;
		end
	end

	assign push.valid  = chars.valid;
	assign push.ready  = push_ready;
	assign chars.ready = push_ready;

endmodule
`default_nettype wire

@@ rtl/core/clt_queue.sv @@
// Short token queue between the front end and the line engine.
`timescale 1ns / 1ps
`default_nettype none
module clt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  clt_pkg::tok_t push_tok,
	output logic          push_ready,
	output logic          pop_valid,
	output clt_pkg::tok_t pop_tok,
	input  logic          pop_ready
);
	import clt_pkg::*;

	tok_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != (Q_AW+1)'(Q_DEPTH)) |-> ((wr_ptr_q - rd_ptr_q) == count_q[Q_AW-1:0]))
		else $error("queue pointers disagree with count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

endmodule
`default_nettype wire

@@ rtl/core/clt_back.sv @@
// Line engine: folds tokens into command and values, and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module clt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_valid,
	input  clt_pkg::tok_t tok,
	output logic          tok_ready,
	clt_out_if.source     tokens
);
	import clt_pkg::*;

	logic [31:0]      cmd_q;
	logic [31:0]      acc_q;
	logic             neg_q;
	logic             at_start_q;
	logic [FI_W-1:0]  fi_q;
	logic [31:0]      store_q [NUM_VALUES];
	logic [LEN_W-1:0] len_q;
	logic [1:0]       err_q;

	logic [31:0]      cmd_d;
	logic [31:0]      acc_d;
	logic             neg_d;
	logic             at_start_d;
	logic [FI_W-1:0]  fi_d;
	logic [31:0]      store_d [NUM_VALUES];
	logic [LEN_W-1:0] len_d;
	logic [1:0]       err_d;

	logic                       out_valid_q;
	logic [31:0]                out_cmd_q;
	logic [OUT_VALUES-1:0][31:0] out_val_q;
	logic [3:0]                 out_count_q;
	logic [1:0]                 out_status_q;

	logic                       pop;
	logic                       emit;
	logic [31:0]                closing;
	logic [31:0]                acc_times_ten;
	logic [OUT_VALUES-1:0][31:0] line_vals;
	logic                       field_open;

	assign tok_ready     = !out_valid_q || tokens.ready;
	assign pop           = tok_valid && tok_ready;
	assign closing       = neg_q ? (32'd0 - acc_q) : acc_q;
	assign acc_times_ten = (acc_q << 3) + (acc_q << 1);
	assign field_open    = (fi_q != '0) && (fi_q <= FI_W'(NUM_VALUES));
	assign emit          = pop && (tok.cls == CLS_TERM) && (len_q != '0);

	always_comb begin
		line_vals = '0;
		for (int k = 0; k < NUM_VALUES; k++) begin
			line_vals[k] = (fi_q == FI_W'(k + 1)) ? closing : store_q[k];
		end
	end

	always_comb begin
		cmd_d      = cmd_q;
		acc_d      = acc_q;
		neg_d      = neg_q;
		at_start_d = at_start_q;
		fi_d       = fi_q;
		store_d    = store_q;
		len_d      = len_q;
		err_d      = err_q;
		if (pop) begin
			if (tok.cls == CLS_TERM) begin
				if (len_q != '0) begin
					cmd_d      = '0;
					acc_d      = '0;
					neg_d      = 1'b0;
					at_start_d = 1'b1;
					fi_d       = '0;
					for (int k = 0; k < NUM_VALUES; k++) begin
						store_d[k] = '0;
					end
					len_d = '0;
					err_d = ST_OK;
				end
			end else if (err_q != ST_TOOLONG) begin
				if (len_q >= LEN_W'(MAX_LINE)) begin
					err_d = ST_TOOLONG;
				end else begin
					len_d = len_q + 1'b1;
					if (tok.cls == CLS_SPACE) begin
						if (fi_q <= FI_W'(NUM_VALUES)) begin
							for (int k = 0; k < NUM_VALUES; k++) begin
								if (fi_q == FI_W'(k + 1)) begin
									store_d[k] = closing;
								end
							end
							acc_d      = '0;
							neg_d      = 1'b0;
							at_start_d = 1'b1;
							fi_d       = fi_q + 1'b1;
							if (fi_q == FI_W'(NUM_VALUES) && err_q == ST_OK) begin
								err_d = ST_TOOMANY;
							end
						end
					end else if (fi_q == '0) begin
						cmd_d = {cmd_q[23:0], tok.ch};
					end else if (field_open) begin
						if (tok.cls == CLS_MINUS && at_start_q) begin
							neg_d = 1'b1;
						end else if (tok.cls == CLS_DIGIT) begin
							acc_d = acc_times_ten + {28'd0, tok.digit};
						end else if (err_q == ST_OK) begin
							err_d = ST_BADCHAR;
						end
						at_start_d = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= '0;
			acc_q      <= '0;
			neg_q      <= 1'b0;
			at_start_q <= 1'b1;
			fi_q       <= '0;
			for (int k = 0; k < NUM_VALUES; k++) begin
				store_q[k] <= '0;
			end
			len_q       <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			cmd_q      <= cmd_d;
			acc_q      <= acc_d;
			neg_q      <= neg_d;
			at_start_q <= at_start_d;
			fi_q       <= fi_d;
			store_q    <= store_d;
			len_q      <= len_d;
			err_q      <= err_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= err_q;
			if (err_q == ST_OK) begin
				out_cmd_q   <= cmd_q;
				out_val_q   <= line_vals;
				out_count_q <= fi_q;
			end else begin
				out_cmd_q   <= '0;
				out_val_q   <= '0;
				out_count_q <= '0;
			end
		end
	end

	assign tokens.valid        = out_valid_q;
	assign tokens.command_word = out_cmd_q;
	assign tokens.value_0      = out_val_q[0];
	assign tokens.value_1      = out_val_q[1];
	assign tokens.value_2      = out_val_q[2];
	assign tokens.value_3      = out_val_q[3];
	assign tokens.value_4      = out_val_q[4];
	assign tokens.value_5      = out_val_q[5];
	assign tokens.value_6      = out_val_q[6];
	assign tokens.value_7      = out_val_q[7];
	assign tokens.value_count  = out_count_q;
	assign tokens.line_status  = out_status_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LINE))
		else $error("line length beyond limit");

	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fi_q <= FI_W'(NUM_VALUES + 1))
		else $error("field index beyond limit");

	a_overflow_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(fi_q == FI_W'(NUM_VALUES + 1)) |-> (err_q != ST_OK))
		else $error("extra field without a fault");

	a_fault_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> (out_count_q == '0 && out_cmd_q == '0))
		else $error("faulty line carries data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !tokens.ready) |=> (out_valid_q && $stable(out_cmd_q)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

@@ test/clt_line_checker.sv @@
// Line checker: predicts each parsed command line from the accepted characters and compares.
`timescale 1ns / 1ps
module clt_line_checker
	import clt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	clt_in_if    chars,
	clt_out_if   tokens,
	output int   mismatches,
	output int   pending,
	output int   chars_seen,
	output int   lines_checked,
	output int   status_count [4]
);

	typedef struct packed {
		logic [31:0]                 command_word;
		logic [OUT_VALUES-1:0][31:0] values;
		logic [3:0]                  value_count;
		logic [1:0]                  line_status;
	} parsed_line_t;

	logic [31:0]  cmd_word;
	logic [31:0]  number;
	logic         negative;
	logic         field_start;
	logic [3:0]   field_idx;
	logic [31:0]  field_values [OUT_VALUES];
	int           line_len;
	logic [1:0]   fault;
	parsed_line_t expected_lines [$];

	function automatic void clear_line();
		cmd_word = '0;
		number = '0;
		negative = 1'b0;
		field_start = 1'b1;
		field_idx = '0;
		foreach (field_values[i]) field_values[i] = '0;
		line_len = 0;
		fault = ST_OK;
	endfunction

	function automatic void note_fault(input logic [1:0] code);
		if (code == ST_TOOLONG || fault == ST_OK) fault = code;
	endfunction

	function automatic void close_number();
		if (field_idx >= 1 && field_idx <= NUM_VALUES && field_idx <= OUT_VALUES) begin
			field_values[field_idx - 1] = negative ? -number : number;
		end
		number = '0;
		negative = 1'b0;
		field_start = 1'b1;
	endfunction

	function automatic void absorb_char(input logic [7:0] ch);
		parsed_line_t line;
		if (ch == CH_LF || ch == CH_CR) begin
			if (line_len != 0) begin
				close_number();
				line = '0;
				if (fault == ST_OK) begin
					line.command_word = cmd_word;
					for (int i = 0; i < OUT_VALUES; i++) line.values[i] = field_values[i];
					line.value_count = field_idx;
				end
				line.line_status = fault;
				expected_lines.push_back(line);
				clear_line();
			end
		end else if (fault != ST_TOOLONG) begin
			if (line_len >= MAX_LINE) begin
				note_fault(ST_TOOLONG);
			end else begin
				line_len++;
				if (ch == CH_SPACE) begin
					if (field_idx <= NUM_VALUES) begin
						close_number();
						field_idx++;
						if (field_idx > NUM_VALUES) note_fault(ST_TOOMANY);
					end
				end else if (field_idx == 0) begin
					cmd_word = {cmd_word[23:0], ch};
				end else if (field_idx <= NUM_VALUES) begin
					if (ch == CH_MINUS && field_start) begin
						negative = 1'b1;
					end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
						number = number * 32'd10 + 32'(ch - CH_ZERO);
					end else begin
						note_fault(ST_BADCHAR);
					end
					field_start = 1'b0;
				end
			end
		end
	endfunction

	function automatic void compare_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s mismatch: expected %h, actual %h", $time, label, want, got);
		end
	endfunction

	task automatic check_line();
		parsed_line_t want;
		logic [31:0]  got_values [OUT_VALUES];
		got_values = '{tokens.value_0, tokens.value_1, tokens.value_2, tokens.value_3,
			tokens.value_4, tokens.value_5, tokens.value_6, tokens.value_7};
		if (expected_lines.size() == 0) begin
			mismatches++;
			$display("%0t unexpected line: expected none, actual command %h status %0d",
				$time, tokens.command_word, tokens.line_status);
			return;
		end
		want = expected_lines.pop_front();
		lines_checked++;
		status_count[want.line_status]++;
		compare_field("command_word", want.command_word, tokens.command_word);
		for (int i = 0; i < OUT_VALUES; i++) begin
			compare_field($sformatf("value_%0d", i), want.values[i], got_values[i]);
		end
		compare_field("value_count", 32'(want.value_count), 32'(tokens.value_count));
		compare_field("line_status", 32'(want.line_status), 32'(tokens.line_status));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			expected_lines.delete();
			mismatches = 0;
			chars_seen = 0;
			lines_checked = 0;
			foreach (status_count[i]) status_count[i] = 0;
			pending <= 0;
		end else begin
			if (tokens.valid && tokens.ready) check_line();
			if (chars.valid && chars.ready) begin
				chars_seen++;
				absorb_char(chars.rx_byte);
			end
			pending <= expected_lines.size();
		end
	end

endmodule

@@ test/tb.sv @@
// Top of the tokenizer regression: clock, reset, character stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module tb;
	import clt_pkg::*;

	localparam int RANDOM_CHARS = 1350;
	localparam int MIN_LINES    = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;

	localparam logic [7:0] DIRECTED_CHARS [24] = '{
		CH_LF,
		8'hFF, CH_SPACE, CH_MINUS, CH_SPACE, CH_NINE, CH_CR,
		CH_LF,
		8'h00, CH_SPACE, "1", CH_MINUS, CH_LF,
		"k", CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE,
		CH_SPACE, CH_SPACE, CH_SPACE, CH_SPACE, CH_LF
	};

	logic       clk = 1'b0;
	logic       arst_n;
	int         cycle_count = 0;
	int         tx_idle_pct;
	int         rx_idle_pct;
	bit         hold_request;
	int         mismatches;
	int         pending;
	int         chars_seen;
	int         lines_checked;
	int         status_count [4];
	logic [7:0] line_chars [$];
	int         chars_sent;
	int         lines_made;

	clt_in_if  chars_if ();
	clt_out_if tokens_if ();

	command_line_tokenizer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	clt_line_checker line_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars_if),
		.tokens        (tokens_if),
		.mismatches    (mismatches),
		.pending       (pending),
		.chars_seen    (chars_seen),
		.lines_checked (lines_checked),
		.status_count  (status_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [7:0] text_char();
		logic [7:0] ch;
		do ch = 8'($urandom_range(255)); while (ch == CH_LF || ch == CH_CR || ch == CH_SPACE);
		return ch;
	endfunction

	task automatic send_char(input logic [7:0] ch);
		if ($urandom_range(99) < tx_idle_pct) begin
			chars_if.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.rx_byte <= ch;
		do @(posedge clk); while (!chars_if.ready);
	endtask

	task automatic add_number(input bit corrupt);
		string      extreme;
		int         nd;
		logic [7:0] bad;
		if ($urandom_range(3) == 0) line_chars.push_back(CH_MINUS);
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: extreme = "2147483647";
				1: extreme = "2147483648";
				2: extreme = "4294967295";
				default: extreme = "18446744073709551615";
			endcase
			for (int i = 0; i < extreme.len(); i++) line_chars.push_back(extreme[i]);
		end else begin
			nd = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(3, 1);
			repeat (nd) line_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
		end
		if (corrupt) begin
			if ($urandom_range(1) == 0) begin
				line_chars.push_back(CH_MINUS);
			end else begin
				do bad = text_char(); while (bad >= CH_ZERO && bad <= CH_NINE);
				line_chars.push_back(bad);
			end
			if ($urandom_range(1) == 0) line_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
		end
	endtask

	task automatic make_line();
		int kind;
		int nfields;
		int corrupt_at;
		int len;
		line_chars.delete();
		kind = $urandom_range(99);
		nfields = $urandom_range(NUM_VALUES);
		corrupt_at = -1;
		len = 0;
		if (lines_made < 2) begin
			len = MAX_LINE + 1 - lines_made;
		end else if (kind < 5) begin
			len = $urandom_range(MAX_LINE + 8, MAX_LINE - 2);
		end else if (kind < 13) begin
			repeat ($urandom_range(16, 1)) line_chars.push_back(8'($urandom_range(255)));
		end else if (kind >= 17) begin
			if (kind < 27) begin
				nfields = $urandom_range(NUM_VALUES + 3, NUM_VALUES + 1);
			end else if (kind < 40) begin
				nfields = $urandom_range(NUM_VALUES, 1);
				corrupt_at = $urandom_range(nfields - 1);
			end
			repeat ($urandom_range(6, 1)) line_chars.push_back(text_char());
			for (int f = 0; f < nfields; f++) begin
				line_chars.push_back(CH_SPACE);
				add_number(f == corrupt_at);
			end
			if ($urandom_range(9) == 0) line_chars.push_back(CH_SPACE);
		end
		repeat (len) line_chars.push_back(text_char());
		case ($urandom_range(2))
			0: line_chars.push_back(CH_LF);
			1: line_chars.push_back(CH_CR);
			default: begin
				line_chars.push_back(CH_CR);
				line_chars.push_back(CH_LF);
			end
		endcase
		chars_sent += (line_chars.size() < MAX_LINE + 2) ? line_chars.size() : MAX_LINE + 2;
		lines_made++;
	endtask

	initial begin
		arst_n <= 1'b0;
		chars_if.valid <= 1'b0;
		chars_if.rx_byte <= '0;
		tx_idle_pct = 10;
		rx_idle_pct = 62;
		hold_request = 1'b0;
		chars_sent = 0;
		lines_made = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_CHARS[i]) send_char(DIRECTED_CHARS[i]);
		while (chars_sent < RANDOM_CHARS || lines_made < MIN_LINES) begin
			make_line();
			foreach (line_chars[i]) send_char(line_chars[i]);
			if (chars_sent >= 2 * RANDOM_CHARS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_request = 1'b1;
			end else if (chars_sent >= RANDOM_CHARS / 3) begin
				tx_idle_pct = 62;
				rx_idle_pct = 10;
			end
		end
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("Fed %0d characters in %0d generated lines; compared %0d parsed lines.",
			chars_seen, lines_made, lines_checked);
		$display("Line status seen: %0d ok, %0d bad character, %0d too many fields, %0d too long.",
			status_count[ST_OK], status_count[ST_BADCHAR], status_count[ST_TOOMANY],
			status_count[ST_TOOLONG]);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : result_receiver
		bit held;
		held = 1'b0;
		tokens_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request && !held) begin
				tokens_if.ready <= 1'b0;
				held = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			tokens_if.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

endmodule

@@ filelist.f @@
rtl/core/clt_pkg.sv
rtl/core/clt_in_if.sv
rtl/core/clt_out_if.sv
rtl/core/clt_front.sv
rtl/core/clt_queue.sv
rtl/core/clt_back.sv
rtl/core/command_line_tokenizer_unit.sv
test/clt_line_checker.sv
test/tb.sv
